// ----- src/ffra_pkg.sv -----
// Package for the first-fit run allocator: payload structs, request codes,
// sequencer states and fixed field widths. Depends on nothing.
package ffra_pkg;

	localparam int SLOTS_DEF       = 64;
	localparam int COUNT_W         = 7;
	localparam int SLOT_W          = 6;
	localparam int OFFSET_W        = 18;
	localparam int OBJ_W           = 13;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic [OBJ_W-1:0] OBJ_BYTES_RESET = 13'd1;

	// Register index, taken from paddr[2] (registers are 4 bytes apart).
	localparam logic REG_OBJECT_BYTES = 1'b0;

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [COUNT_W-1:0] count;
		logic [SLOT_W-1:0]  start_slot;
	} req_t;

	typedef struct packed {
		logic                granted;
		logic [SLOT_W-1:0]   grant_slot;
		logic [OFFSET_W-1:0] grant_offset;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_MARK,
		ST_FREE,
		ST_DONE
	} state_t;

endpackage

// ----- src/ffra_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the slot occupancy map.
module ffra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/ffra_ctrl.sv -----
// Sequencer and shared slot walker of the allocator: clearing pass, first-fit
// scan, offset multiply, mark and free loops. Uses ffra_pkg and ffra_ram.
module ffra_ctrl #(
	parameter int SLOTS = ffra_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  ffra_pkg::req_t                 req,
	input  logic [ffra_pkg::OBJ_W-1:0]     obj_bytes,
	output logic                           busy,
	output logic                           done,
	output ffra_pkg::rsp_t                 rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int PW = AW + ffra_pkg::OBJ_W;

	ffra_pkg::state_t state_q, state_d;

	logic [CW-1:0]                idx_q;
	logic [ffra_pkg::COUNT_W-1:0] cnt_q;
	logic [ffra_pkg::COUNT_W-1:0] rem_q;
	logic [ffra_pkg::COUNT_W-1:0] run_q;
	logic [ffra_pkg::COUNT_W-1:0] run_inc;
	logic [AW-1:0]                run_start_q;
	logic [AW-1:0]                pos_q;
	logic                         chk_vld_s1;
	logic [AW-1:0]                chk_idx_s1;
	ffra_pkg::rsp_t               rsp_q;

	logic          ram_we;
	logic          ram_wdata;
	logic          ram_rdata;
	logic          at_end;
	logic          last_chk;
	logic          hit;
	logic          miss;
	logic [AW-1:0] hit_pos;
	logic          start_ok;
	logic          too_big;
	logic          walk_wr;
	logic [PW-1:0] prod;

	ffra_ram #(
		.WIDTH(1),
		.DEPTH(SLOTS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign at_end   = (idx_q == CW'(SLOTS));
	assign last_chk = (chk_idx_s1 == AW'(SLOTS - 1));
	assign run_inc  = run_q + 1'b1;
	assign hit      = chk_vld_s1 && !ram_rdata && ((cnt_q == '0) || (run_inc == cnt_q));
	assign miss     = chk_vld_s1 && !hit && last_chk;
	assign hit_pos  = ((cnt_q == '0) || (run_q == '0)) ? chk_idx_s1 : run_start_q;
	assign start_ok = (int'(req.start_slot) < SLOTS);
	assign too_big  = (int'(req.count) > SLOTS);
	assign walk_wr  = (rem_q != '0) && !at_end;
	assign prod     = PW'(pos_q) * PW'(obj_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffra_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_wdata = 1'b0;
		case (state_q)
			ffra_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (idx_q == CW'(SLOTS - 1)) begin
					state_d = ffra_pkg::ST_IDLE;
				end
			end
			ffra_pkg::ST_IDLE: begin
				if (start) begin
					if (req.req_type == ffra_pkg::REQ_FREE) begin
						state_d = start_ok ? ffra_pkg::ST_FREE : ffra_pkg::ST_DONE;
					end else begin
						state_d = too_big ? ffra_pkg::ST_DONE : ffra_pkg::ST_SCAN;
					end
				end
			end
			ffra_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = ffra_pkg::ST_MUL;
				end else if (miss) begin
					state_d = ffra_pkg::ST_DONE;
				end
			end
			ffra_pkg::ST_MUL: begin
				state_d = ffra_pkg::ST_MARK;
			end
			ffra_pkg::ST_MARK: begin
				ram_we    = walk_wr;
				ram_wdata = 1'b1;
				if (!walk_wr) begin
					state_d = ffra_pkg::ST_DONE;
				end
			end
			ffra_pkg::ST_FREE: begin
				ram_we = walk_wr;
				if (!walk_wr) begin
					state_d = ffra_pkg::ST_DONE;
				end
			end
			ffra_pkg::ST_DONE: begin
				state_d = ffra_pkg::ST_IDLE;
			end
			default: begin
				state_d = ffra_pkg::ST_IDLE;
			end
		endcase
	end

	// Walker counters and scan pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rem_q      <= '0;
			run_q      <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ffra_pkg::ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
				end
				ffra_pkg::ST_IDLE: begin
					rem_q      <= req.count;
					run_q      <= '0;
					chk_vld_s1 <= 1'b0;
					if (req.req_type == ffra_pkg::REQ_FREE && start_ok) begin
						idx_q <= CW'(req.start_slot);
					end else begin
						idx_q <= '0;
					end
				end
				ffra_pkg::ST_SCAN: begin
					chk_vld_s1 <= !at_end;
					if (!at_end) begin
						idx_q <= idx_q + 1'b1;
					end
					if (chk_vld_s1) begin
						run_q <= ram_rdata ? '0 : run_inc;
					end
				end
				ffra_pkg::ST_MUL: begin
					idx_q <= CW'(pos_q);
					rem_q <= cnt_q;
				end
				ffra_pkg::ST_MARK, ffra_pkg::ST_FREE: begin
					if (walk_wr) begin
						idx_q <= idx_q + 1'b1;
						rem_q <= rem_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ffra_pkg::ST_IDLE: begin
				if (start) begin
					cnt_q              <= req.count;
					rsp_q.granted      <= (req.req_type == ffra_pkg::REQ_FREE);
					rsp_q.grant_slot   <= '0;
					rsp_q.grant_offset <= '0;
				end
			end
			ffra_pkg::ST_SCAN: begin
				chk_idx_s1 <= idx_q[AW-1:0];
				if (chk_vld_s1 && !ram_rdata && (run_q == '0)) begin
					run_start_q <= chk_idx_s1;
				end
				if (hit) begin
					pos_q <= hit_pos;
				end
			end
			ffra_pkg::ST_MUL: begin
				rsp_q.granted      <= 1'b1;
				rsp_q.grant_slot   <= ffra_pkg::SLOT_W'(pos_q);
				rsp_q.grant_offset <= ffra_pkg::OFFSET_W'(prod);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ffra_pkg::ST_IDLE);
	assign done = (state_q == ffra_pkg::ST_DONE);
	assign rsp  = rsp_q;

endmodule

// ----- src/first_fit_run_allocator_core.sv -----
// First-fit run allocator. After the accepting edge an allocate runs the first-fit
// scan, the offset multiply, the mark loop and the result state; a free walks count
// slots (count clamped at the pool end), one slot per cycle through the single write
// port of the slot map. A failed allocate ends after its scan, or without a scan
// if count exceeds SLOTS. Throughput is one word at a time: start is taken only
// while busy is low. After reset a clearing pass zeroes the map, with busy high;
// the result strobe is one cycle wide and the receiver cannot stall it.
// Depends on ffra_pkg and ffra_ctrl.
module first_fit_run_allocator_core #(
	parameter int SLOTS = ffra_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  ffra_pkg::req_t                   req,
	output logic                             busy,
	output logic                             done,
	output ffra_pkg::rsp_t                   rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ffra_pkg::PADDR_W-1:0]     paddr,
	input  logic [ffra_pkg::PDATA_W-1:0]     pwdata,
	output logic [ffra_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	// The only register is the slot size. It resets to one byte, so the
	// granted offset equals the slot index until software programs it.
	logic [ffra_pkg::OBJ_W-1:0] obj_bytes_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_bytes_q <= ffra_pkg::OBJ_BYTES_RESET;
		end else if (wr_en && (paddr[2] == ffra_pkg::REG_OBJECT_BYTES)) begin
			obj_bytes_q <= pwdata[ffra_pkg::OBJ_W-1:0];
		end
	end

	// Reads of addresses past the register return zero.
	assign prdata = (paddr[2] == ffra_pkg::REG_OBJECT_BYTES) ?
		ffra_pkg::PDATA_W'(obj_bytes_q) : '0;

	// The sequencer owns the slot map and walks it one slot per cycle for
	// the clearing pass, the first-fit scan, and the mark and free loops.
	ffra_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.obj_bytes(obj_bytes_q),
		.busy     (busy),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

// ----- src/ffra_checker.sv -----
// Port-level checker for the first-fit run allocator, bound to the top level.
// Depends on ffra_pkg.
module ffra_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input ffra_pkg::rsp_t rsp
);

	// An accepted word makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a word");

	// The result strobe only appears while the block is still busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// A result strobe lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A failed allocation reports slot and offset zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.granted) |-> (rsp.grant_slot == '0 && rsp.grant_offset == '0))
		else $error("failed allocation with nonzero slot or offset");

endmodule

bind first_fit_run_allocator_core ffra_checker u_ffra_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
